// ----- rtl/core/adm_pkg.sv -----
// shared constants, widths, register codes and reset values for the arcade drive mixer
package adm_pkg;

    // full scale of every command
    localparam int SCALE = 1000;

    // field widths
    localparam int CMD_W      = 11;
    localparam int OUT_W      = 16;
    localparam int FLIP_W     = 3;
    localparam int CTR_W      = 12;
    localparam int TRIM_W     = 11;
    localparam int GAIN_W     = 12;
    localparam int DZ_W       = 10;
    localparam int LIM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // internal widths
    localparam int SUM_W  = CMD_W + 1;
    localparam int X_W    = SUM_W + 1;
    localparam int SMAG_W = $clog2(SCALE + 1);
    localparam int Q_W    = SMAG_W + 1;
    localparam int MIX_W  = SMAG_W + X_W + 2;
    localparam int MMAG_W = MIX_W - 1;
    localparam int PM_W   = SMAG_W + GAIN_W;
    localparam int SRV_W  = 14;

    // mixer divides by twice the scale, the servo stage by the scale
    localparam int MIX_DIV = 2 * SCALE;
    localparam longint unsigned MIX_RCP = (64'd1 << MMAG_W) / MIX_DIV;
    localparam int MIX_RCP_W = $clog2(MIX_RCP + 1);
    localparam longint unsigned SRV_RCP = (64'd1 << PM_W) / SCALE;
    localparam int SRV_RCP_W = $clog2(SRV_RCP + 1);

    localparam logic signed [Q_W-1:0] MIX_MAX = Q_W'(SCALE);

    // pipeline depth
    localparam int N_STG = 10;

    // sides
    localparam int NSIDE  = 2;
    localparam int SIDE_L = 0;
    localparam int SIDE_R = 1;

    // flip_mode bits
    localparam int FLIP_SWAP  = 0;
    localparam int FLIP_REV_L = 1;
    localparam int FLIP_REV_R = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLIP_MODE  = 3'd0,
        CFG_SRV_ENABLE = 3'd1,
        CFG_CENTER     = 3'd2,
        CFG_TRIM       = 3'd3,
        CFG_GAIN       = 3'd4,
        CFG_DEADZONE   = 3'd5,
        CFG_LIMIT_HIGH = 3'd6,
        CFG_LIMIT_LOW  = 3'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [FLIP_W-1:0]        RST_FLIP     = '0;
    localparam logic                     RST_SRV_EN   = 1'b1;
    localparam logic [CTR_W-1:0]         RST_CENTER   = 12'd1500;
    localparam logic signed [TRIM_W-1:0] RST_TRIM     = '0;
    localparam logic [GAIN_W-1:0]        RST_GAIN     = 12'd1000;
    localparam logic [DZ_W-1:0]          RST_DEADZONE = '0;
    localparam logic signed [LIM_W-1:0]  RST_LIM_HI   = 16'sd2000;
    localparam logic signed [LIM_W-1:0]  RST_LIM_LO   = 16'sd1000;

endpackage

// ----- rtl/core/adm_if.sv -----
// handshake channels of the arcade drive mixer: commands, drive results, register writes
interface adm_cmd_if import adm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [CMD_W-1:0]  throttle_cmd;
    logic signed [CMD_W-1:0]  steer_cmd;
    logic signed [CMD_W-1:0]  gyro_trim_cmd;

    modport source (output valid, output throttle_cmd, output steer_cmd,
                    output gyro_trim_cmd, input ready);
    modport sink   (input valid, input throttle_cmd, input steer_cmd,
                    input gyro_trim_cmd, output ready);
endinterface

interface adm_drive_if import adm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  left_drive;
    logic signed [OUT_W-1:0]  right_drive;

    modport source (output valid, output left_drive, output right_drive, input ready);
    modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

interface adm_cfg_if import adm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/arcade_drive_mixer_servo_out_top.sv -----
// arcade drive mixer with flips and per-side servo output stage, ten-stage pipeline
//
//  channel  dir  payload                                   beat when
//  i_cmd    in   throttle_cmd, steer_cmd, gyro_trim_cmd    valid && ready
//  o_drv    out  left_drive, right_drive                   valid && ready
//  i_cfg    in   index, data                               valid && ready (ready tied high)
//
//  one command beat per cycle unless the full pipeline stalls; results keep order
//  the depth is set by the two constant reciprocal dividers and the gain multiplier
//  each stage holds while the one after it is full and stalled, so bubbles close up
//  synchronous active-low reset empties the pipeline and loads register defaults
module arcade_drive_mixer_servo_out_top
    import adm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    adm_cfg_if.sink      i_cfg,
    adm_cmd_if.sink      i_cmd,
    adm_drive_if.source  o_drv
);

    localparam logic signed [MIX_W-1:0] SCALE_MIX = MIX_W'(SCALE);
    localparam int P1_W = MMAG_W + MIX_RCP_W;
    localparam int P2_W = PM_W + SRV_RCP_W;

    // configuration registers
    logic [FLIP_W-1:0]         r_flip;
    logic                      r_srv_en;
    logic [CTR_W-1:0]          r_center;
    logic signed [TRIM_W-1:0]  r_trim;
    logic [GAIN_W-1:0]         r_gain;
    logic [DZ_W-1:0]           r_dz;
    logic signed [LIM_W-1:0]   r_lim_hi;
    logic signed [LIM_W-1:0]   r_lim_lo;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip   <= RST_FLIP;
            r_srv_en <= RST_SRV_EN;
            r_center <= RST_CENTER;
            r_trim   <= RST_TRIM;
            r_gain   <= RST_GAIN;
            r_dz     <= RST_DEADZONE;
            r_lim_hi <= RST_LIM_HI;
            r_lim_lo <= RST_LIM_LO;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FLIP_MODE:  r_flip   <= i_cfg.data[FLIP_W-1:0];
                CFG_SRV_ENABLE: r_srv_en <= i_cfg.data[0];
                CFG_CENTER:     r_center <= i_cfg.data[CTR_W-1:0];
                CFG_TRIM:       r_trim   <= signed'(i_cfg.data[TRIM_W-1:0]);
                CFG_GAIN:       r_gain   <= i_cfg.data[GAIN_W-1:0];
                CFG_DEADZONE:   r_dz     <= i_cfg.data[DZ_W-1:0];
                CFG_LIMIT_HIGH: r_lim_hi <= signed'(i_cfg.data[LIM_W-1:0]);
                CFG_LIMIT_LOW:  r_lim_lo <= signed'(i_cfg.data[LIM_W-1:0]);
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic [N_STG:1]   r_vld;
    logic [N_STG+1:1] en;

    always_comb begin
        en[N_STG+1] = o_drv.ready;
        for (int k = N_STG; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_cmd.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_cmd.valid;
            end
            for (int k = 2; k <= N_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: saturate throttle and steering sum, negate steering
    logic signed [SUM_W-1:0] s0_sum;
    logic signed [SUM_W-1:0] s0_st;
    logic signed [CMD_W-1:0] n_t;
    logic signed [X_W-1:0]   n_x;
    logic signed [CMD_W-1:0] r_t;
    logic signed [X_W-1:0]   r_x;

    always_comb begin
        s0_sum = SUM_W'(i_cmd.steer_cmd) + SUM_W'(i_cmd.gyro_trim_cmd);
        if (int'(i_cmd.throttle_cmd) > SCALE) begin
            n_t = CMD_W'(SCALE);
        end else if (int'(i_cmd.throttle_cmd) < -SCALE) begin
            n_t = CMD_W'(-SCALE);
        end else begin
            n_t = i_cmd.throttle_cmd;
        end
        if (int'(s0_sum) > SCALE) begin
            s0_st = SUM_W'(SCALE);
        end else if (int'(s0_sum) < -SCALE) begin
            s0_st = SUM_W'(-SCALE);
        end else begin
            s0_st = s0_sum;
        end
        n_x = -X_W'(s0_st);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_t <= n_t;
            r_x <= n_x;
        end
    end

    // stage 2: V and W, both carrying one factor of scale
    logic signed [MIX_W-1:0] s1_tm, s1_xm, s1_abs_t, s1_abs_x;
    logic signed [MIX_W-1:0] n_v, n_w, r_v, r_w;

    always_comb begin
        s1_tm    = MIX_W'(r_t);
        s1_xm    = MIX_W'(r_x);
        s1_abs_t = (s1_tm < 0) ? -s1_tm : s1_tm;
        s1_abs_x = (s1_xm < 0) ? -s1_xm : s1_xm;
        n_v = (SCALE_MIX - s1_abs_x) * s1_tm + s1_tm * SCALE_MIX;
        n_w = (SCALE_MIX - s1_abs_t) * s1_xm + s1_xm * SCALE_MIX;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_v <= n_v;
            r_w <= n_w;
        end
    end

    // stage 3: sum and difference as sign and magnitude
    logic signed [MIX_W-1:0] s2_sum [NSIDE];
    logic [MMAG_W-1:0]       n_mag3 [NSIDE];
    logic                    n_neg3 [NSIDE];
    logic [MMAG_W-1:0]       r_mag3 [NSIDE];
    logic                    r_neg3 [NSIDE];

    always_comb begin
        s2_sum[SIDE_R] = r_v + r_w;
        s2_sum[SIDE_L] = r_v - r_w;
        for (int i = 0; i < NSIDE; i++) begin
            n_neg3[i] = s2_sum[i] < 0;
            n_mag3[i] = MMAG_W'(n_neg3[i] ? -s2_sum[i] : s2_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_mag3 <= n_mag3;
            r_neg3 <= n_neg3;
        end
    end

    // stage 4: quotient estimate by reciprocal, low by at most one
    logic [P1_W-1:0]   s3_prod [NSIDE];
    logic [SMAG_W-1:0] n_q4 [NSIDE];
    logic [SMAG_W-1:0] r_q4 [NSIDE];
    logic [MMAG_W-1:0] r_mag4 [NSIDE];
    logic              r_neg4 [NSIDE];

    always_comb begin
        for (int i = 0; i < NSIDE; i++) begin
            s3_prod[i] = P1_W'(r_mag3[i]) * P1_W'(MIX_RCP);
            n_q4[i]    = SMAG_W'(s3_prod[i] >> MMAG_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_q4   <= n_q4;
            r_mag4 <= r_mag3;
            r_neg4 <= r_neg3;
        end
    end

    // stage 5: remainder correction and sign, truncation toward zero
    logic [MMAG_W-1:0]       s4_rem [NSIDE];
    logic [SMAG_W-1:0]       s4_q [NSIDE];
    logic signed [Q_W-1:0]   n_mix [NSIDE];
    logic signed [Q_W-1:0]   r_mix [NSIDE];

    always_comb begin
        for (int i = 0; i < NSIDE; i++) begin
            s4_rem[i] = r_mag4[i] - MMAG_W'(r_q4[i]) * MMAG_W'(MIX_DIV);
            s4_q[i]   = (s4_rem[i] >= MMAG_W'(MIX_DIV)) ? r_q4[i] + 1'b1 : r_q4[i];
            n_mix[i]  = r_neg4[i] ? -signed'(Q_W'(s4_q[i])) : signed'(Q_W'(s4_q[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_mix <= n_mix;
        end
    end

    // stage 6: swap and per-side reversal
    logic signed [Q_W-1:0] s5_a [NSIDE];
    logic signed [Q_W-1:0] n_s6 [NSIDE];
    logic signed [Q_W-1:0] r_s6 [NSIDE];

    always_comb begin
        s5_a[SIDE_L] = r_flip[FLIP_SWAP] ? r_mix[SIDE_R] : r_mix[SIDE_L];
        s5_a[SIDE_R] = r_flip[FLIP_SWAP] ? r_mix[SIDE_L] : r_mix[SIDE_R];
        n_s6[SIDE_L] = r_flip[FLIP_REV_L] ? -s5_a[SIDE_L] : s5_a[SIDE_L];
        n_s6[SIDE_R] = r_flip[FLIP_REV_R] ? -s5_a[SIDE_R] : s5_a[SIDE_R];
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6 <= n_s6;
        end
    end

    // stage 7: speed magnitude times gain
    logic [SMAG_W-1:0]     s6_mag [NSIDE];
    logic                  n_neg7 [NSIDE];
    logic                  n_zero7 [NSIDE];
    logic [PM_W-1:0]       n_pm7 [NSIDE];
    logic                  r_neg7 [NSIDE];
    logic                  r_zero7 [NSIDE];
    logic [PM_W-1:0]       r_pm7 [NSIDE];
    logic signed [Q_W-1:0] r_s7 [NSIDE];

    always_comb begin
        for (int i = 0; i < NSIDE; i++) begin
            n_neg7[i]  = r_s6[i] < 0;
            n_zero7[i] = r_s6[i] == '0;
            s6_mag[i]  = SMAG_W'(n_neg7[i] ? -r_s6[i] : r_s6[i]);
            n_pm7[i]   = PM_W'(s6_mag[i]) * PM_W'(r_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_neg7  <= n_neg7;
            r_zero7 <= n_zero7;
            r_pm7   <= n_pm7;
            r_s7    <= r_s6;
        end
    end

    // stage 8: divide by scale, reciprocal estimate
    logic [P2_W-1:0]       s7_prod [NSIDE];
    logic [GAIN_W-1:0]     n_q8 [NSIDE];
    logic [GAIN_W-1:0]     r_q8 [NSIDE];
    logic [PM_W-1:0]       r_pm8 [NSIDE];
    logic                  r_neg8 [NSIDE];
    logic                  r_zero8 [NSIDE];
    logic signed [Q_W-1:0] r_s8 [NSIDE];

    always_comb begin
        for (int i = 0; i < NSIDE; i++) begin
            s7_prod[i] = P2_W'(r_pm7[i]) * P2_W'(SRV_RCP);
            n_q8[i]    = GAIN_W'(s7_prod[i] >> PM_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_q8    <= n_q8;
            r_pm8   <= r_pm7;
            r_neg8  <= r_neg7;
            r_zero8 <= r_zero7;
            r_s8    <= r_s7;
        end
    end

    // stage 9: remainder correction of the scaled speed
    logic [PM_W-1:0]       s8_rem [NSIDE];
    logic [GAIN_W-1:0]     n_q9 [NSIDE];
    logic [GAIN_W-1:0]     r_q9 [NSIDE];
    logic                  r_neg9 [NSIDE];
    logic                  r_zero9 [NSIDE];
    logic signed [Q_W-1:0] r_s9 [NSIDE];

    always_comb begin
        for (int i = 0; i < NSIDE; i++) begin
            s8_rem[i] = r_pm8[i] - PM_W'(r_q8[i]) * PM_W'(SCALE);
            n_q9[i]   = (s8_rem[i] >= PM_W'(SCALE)) ? r_q8[i] + 1'b1 : r_q8[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_q9    <= n_q9;
            r_neg9  <= r_neg8;
            r_zero9 <= r_zero8;
            r_s9    <= r_s8;
        end
    end

    // stage 10: deadzone, trim, clamp, zero-speed centre and bypass
    logic signed [SRV_W-1:0] s9_q [NSIDE];
    logic signed [SRV_W-1:0] s9_dz [NSIDE];
    logic signed [SRV_W-1:0] s9_sum [NSIDE];
    logic signed [SRV_W-1:0] s9_ctr;
    logic signed [OUT_W-1:0] s9_clamp [NSIDE];
    logic signed [OUT_W-1:0] n_out [NSIDE];
    logic signed [OUT_W-1:0] r_out [NSIDE];

    always_comb begin
        s9_ctr = signed'(SRV_W'(r_center)) + SRV_W'(r_trim);
        for (int i = 0; i < NSIDE; i++) begin
            s9_q[i]   = r_neg9[i] ? -signed'(SRV_W'(r_q9[i])) : signed'(SRV_W'(r_q9[i]));
            s9_dz[i]  = r_neg9[i] ? -signed'(SRV_W'(r_dz)) : signed'(SRV_W'(r_dz));
            s9_sum[i] = s9_q[i] + s9_dz[i] + SRV_W'(r_trim);
            // upper bound first, so crossed limits give the lower one
            s9_clamp[i] = OUT_W'(s9_sum[i]);
            if (s9_clamp[i] > r_lim_hi) begin
                s9_clamp[i] = r_lim_hi;
            end
            if (s9_clamp[i] < r_lim_lo) begin
                s9_clamp[i] = r_lim_lo;
            end
            if (!r_srv_en) begin
                n_out[i] = OUT_W'(r_s9[i]);
            end else if (r_zero9[i]) begin
                n_out[i] = OUT_W'(s9_ctr);
            end else begin
                n_out[i] = s9_clamp[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_out <= n_out;
        end
    end

    assign o_drv.valid       = r_vld[N_STG];
    assign o_drv.left_drive  = r_out[SIDE_L];
    assign o_drv.right_drive = r_out[SIDE_R];

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_vld[1])
        else $error("accepted command did not enter the pipeline");

    a_stall_holds_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && !en[5] |=> r_vld[5] && $stable(r_mix[SIDE_L]) && $stable(r_mix[SIDE_R]))
        else $error("stalled mixer stage lost or changed its beat");

    a_mix_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> r_mix[SIDE_L] <= MIX_MAX && r_mix[SIDE_L] >= -MIX_MAX &&
                     r_mix[SIDE_R] <= MIX_MAX && r_mix[SIDE_R] >= -MIX_MAX)
        else $error("mixed value beyond full scale");

    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_drv.valid && o_drv.ready && !r_vld[N_STG-1] |=> !o_drv.valid)
        else $error("result beat repeated");
`endif

endmodule

// ----- dv/adm_mixer_checker.sv -----
// checker for the arcade drive mixer: follows register writes, predicts each drive beat, compares
module adm_mixer_checker
    import adm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    adm_cfg_if    cfg,
    adm_cmd_if    cmd,
    adm_drive_if  drv,
    output int    o_errors,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } t_drive;

    // shadow copy of the register file
    logic [FLIP_W-1:0]        flip_mode;
    logic                     srv_en;
    logic [CTR_W-1:0]         center;
    logic signed [TRIM_W-1:0] trim;
    logic [GAIN_W-1:0]        gain;
    logic [DZ_W-1:0]          deadzone;
    logic signed [LIM_W-1:0]  lim_hi;
    logic signed [LIM_W-1:0]  lim_lo;

    t_drive pending_drives[$];

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint servo_map(longint spd);
        longint r;
        if (!srv_en) return spd;
        if (spd == 0) return longint'(center) + longint'(trim);
        r = (spd * longint'(gain)) / SCALE;
        // deadzone follows the sign of the unscaled speed
        r += (spd > 0) ? longint'(deadzone) : -longint'(deadzone);
        r += longint'(trim);
        // upper bound first, so crossed limits give the lower bound
        if (r > lim_hi) r = lim_hi;
        if (r < lim_lo) r = lim_lo;
        return r;
    endfunction

    function automatic t_drive mix_drive(logic signed [CMD_W-1:0] thr,
                                         logic signed [CMD_W-1:0] str,
                                         logic signed [CMD_W-1:0] gyr);
        longint t, x, v, w, l, r, tmp, abs_t, abs_x;
        t_drive d;
        t = clip(longint'(thr), SCALE);
        x = -clip(longint'(str) + longint'(gyr), SCALE);
        abs_t = (t < 0) ? -t : t;
        abs_x = (x < 0) ? -x : x;
        v = (SCALE - abs_x) * t + t * SCALE;
        w = (SCALE - abs_t) * x + x * SCALE;
        r = ((v + w) / 2) / SCALE;
        l = ((v - w) / 2) / SCALE;
        if (flip_mode[FLIP_SWAP]) begin
            tmp = r;
            r = l;
            l = tmp;
        end
        if (flip_mode[FLIP_REV_L]) l = -l;
        if (flip_mode[FLIP_REV_R]) r = -r;
        d.left  = OUT_W'(servo_map(l));
        d.right = OUT_W'(servo_map(r));
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_drive want;
        if (!i_rst_n) begin
            flip_mode = RST_FLIP;
            srv_en    = RST_SRV_EN;
            center    = RST_CENTER;
            trim      = RST_TRIM;
            gain      = RST_GAIN;
            deadzone  = RST_DEADZONE;
            lim_hi    = RST_LIM_HI;
            lim_lo    = RST_LIM_LO;
            pending_drives.delete();
            o_errors  = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (t_cfg_idx'(cfg.index))
                    CFG_FLIP_MODE:  flip_mode = cfg.data[FLIP_W-1:0];
                    CFG_SRV_ENABLE: srv_en    = cfg.data[0];
                    CFG_CENTER:     center    = cfg.data[CTR_W-1:0];
                    CFG_TRIM:       trim      = cfg.data[TRIM_W-1:0];
                    CFG_GAIN:       gain      = cfg.data[GAIN_W-1:0];
                    CFG_DEADZONE:   deadzone  = cfg.data[DZ_W-1:0];
                    CFG_LIMIT_HIGH: lim_hi    = cfg.data[LIM_W-1:0];
                    CFG_LIMIT_LOW:  lim_lo    = cfg.data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
                pending_drives.push_back(mix_drive(cmd.throttle_cmd, cmd.steer_cmd,
                                                   cmd.gyro_trim_cmd));
            if (drv.valid && drv.ready) begin
                if (pending_drives.size() == 0) begin
                    $error("drive beat with no command outstanding: left_drive %0d right_drive %0d",
                           drv.left_drive, drv.right_drive);
                    o_errors++;
                end else begin
                    want = pending_drives.pop_front();
                    if (drv.left_drive !== want.left) begin
                        $error("left_drive mismatch: expected %0d, got %0d",
                               want.left, drv.left_drive);
                        o_errors++;
                    end
                    if (drv.right_drive !== want.right) begin
                        $error("right_drive mismatch: expected %0d, got %0d",
                               want.right, drv.right_drive);
                        o_errors++;
                    end
                end
            end
        end
        o_outstanding = pending_drives.size();
    end

endmodule

// ----- dv/arcade_drive_mixer_servo_out_top_tb.sv -----
// testbench top for the arcade drive mixer: clock, reset, command and register stimulus, verdict
module arcade_drive_mixer_servo_out_top_tb
    import adm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    adm_cmd_if   cmd_ch();
    adm_drive_if drv_ch();
    adm_cfg_if   cfg_ch();

    int errors;
    int outstanding;
    int hold_cycles = 0;
    bit src_idle    = 1'b1;
    bit snk_idle    = 1'b1;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    arcade_drive_mixer_servo_out_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_cmd   (cmd_ch),
        .o_drv   (drv_ch)
    );

    adm_mixer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cfg           (cfg_ch),
        .cmd           (cmd_ch),
        .drv           (drv_ch),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (drv_ch.valid && drv_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // drive sink: random back-pressure, plus one long hold when asked
    initial begin
        int gap;
        int beats;
        beats = 0;
        drv_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                drv_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = snk_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                drv_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            drv_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!drv_ch.valid);
            beats++;
            if (beats % 40 == 0) snk_idle = $urandom_range(0, 1);
        end
    end

    function automatic logic [CFG_DATA_W-1:0] pad(int val, int w, bit junk);
        logic [CFG_DATA_W-1:0] m;
        logic [CFG_DATA_W-1:0] r;
        m = (w >= CFG_DATA_W) ? '1 : CFG_DATA_W'((32'd1 << w) - 1);
        r = CFG_DATA_W'(val) & m;
        // unused upper bits must be ignored by the block
        if (junk) r = r | (CFG_DATA_W'($urandom) & ~m);
        return r;
    endfunction

    function automatic int pick_cmd();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = $urandom_range(0, 6) - 3;
            2: v = $urandom_range(0, 2047) - 1024;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = -1024;
                    1: v = -SCALE;
                    2: v = SCALE;
                    default: v = 1023;
                endcase
            end
            default: v = $urandom_range(0, 2 * SCALE) - SCALE;
        endcase
        return v;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic load_settings(int flip, int en, int ctr, int trm, int gn, int dz,
                                 int hi, int lo, bit junk);
        write_reg(CFG_FLIP_MODE,  pad(flip, FLIP_W, junk));
        write_reg(CFG_SRV_ENABLE, pad(en, 1, junk));
        write_reg(CFG_CENTER,     pad(ctr, CTR_W, junk));
        write_reg(CFG_TRIM,       pad(trm, TRIM_W, junk));
        write_reg(CFG_GAIN,       pad(gn, GAIN_W, junk));
        write_reg(CFG_DEADZONE,   pad(dz, DZ_W, junk));
        write_reg(CFG_LIMIT_HIGH, pad(hi, LIM_W, junk));
        write_reg(CFG_LIMIT_LOW,  pad(lo, LIM_W, junk));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_cmd(int thr, int str, int gyr);
        int gap;
        gap = src_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.throttle_cmd  <= CMD_W'(thr);
        cmd_ch.steer_cmd     <= CMD_W'(str);
        cmd_ch.gyro_trim_cmd <= CMD_W'(gyr);
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        int dir_t[13];
        int dir_s[13];
        int dir_g[13];
        int flip, en, ctr, trm, gn, dz, hi, lo, n;
        bit junk;

        // zero speed, tiny speeds, throttle and steering extremes, saturating sums
        dir_t = '{0, 3, -3, 1000, -1000, 0, 1023, -1024, 0, 0, 0, 500, 1000};
        dir_s = '{0, 2, 0, 0, 0, 1000, 0, 0, -1000, 1000, -1024, 1023, 1000};
        dir_g = '{0, 0, -1, 0, 0, 0, 0, 0, 0, 1000, -1024, -1024, 0};

        i_rst_n              <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.throttle_cmd  <= '0;
        cmd_ch.steer_cmd     <= '0;
        cmd_ch.gyro_trim_cmd <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_FLIP_MODE;
        cfg_ch.data          <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults
        for (int i = 0; i < 13; i++) send_cmd(dir_t[i], dir_s[i], dir_g[i]);
        drain();

        // tiny gain so the deadzone alone moves small speeds
        load_settings(0, 1, 0, -3, 1, 7, 32767, -32768, 1'b0);
        for (int i = 0; i < 6; i++) send_cmd(dir_t[i], dir_s[i], dir_g[i]);
        drain();

        // crossed limits
        load_settings(0, 1, 1500, 0, 1000, 0, 1200, 1800, 1'b0);
        for (int i = 0; i < 5; i++) send_cmd(dir_t[i], dir_s[i], dir_g[i]);
        drain();

        for (int k = 0; k < 10; k++) begin
            flip = $urandom_range(0, 7);
            en   = ($urandom_range(0, 3) != 0);
            ctr  = $urandom_range(0, 4095);
            trm  = $urandom_range(0, 2000) - 1000;
            gn   = $urandom_range(0, 4000);
            dz   = $urandom_range(0, 1000);
            if ($urandom_range(0, 3) == 0) begin
                hi = $urandom_range(0, 65535) - 32768;
                lo = $urandom_range(0, 65535) - 32768;
            end else begin
                lo = $urandom_range(0, 3000) - 1500;
                hi = lo + $urandom_range(0, 4000) - 500;
            end
            junk = (k >= 3) && ($urandom_range(0, 1) == 1);
            case (k)
                0: begin
                    flip = 0; en = 1; ctr = 0; trm = -1000; gn = 0; dz = 0;
                    hi = 32767; lo = -32768;
                end
                1: begin
                    flip = 7; en = 1; ctr = 4095; trm = 1000; gn = 4000; dz = 1000;
                    hi = -32768; lo = 32767;
                end
                2: en = 0;
                default: ;
            endcase
            load_settings(flip, en, ctr, trm, gn, dz, hi, lo, junk);

            n = 50;
            src_idle = (k % 3 != 1);
            if (k == 3) begin
                // sink stalls long while commands keep coming, so the pipeline backs up
                src_idle = 1'b0;
                hold_cycles = HOLD_LEN;
                n = 60;
            end
            for (int i = 0; i < n; i++)
                send_cmd(pick_cmd(), pick_cmd(),
                         ($urandom_range(0, 9) < 6) ? $urandom_range(0, 200) - 100
                                                    : pick_cmd());
            drain();
        end

        repeat (2 * N_STG) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/adm_pkg.sv
rtl/core/adm_if.sv
rtl/core/arcade_drive_mixer_servo_out_top.sv
dv/adm_mixer_checker.sv
dv/arcade_drive_mixer_servo_out_top_tb.sv
